@@ hdl/csg_pkg.sv @@
`default_nettype none
package csg_pkg;
  localparam int CW    = 32;            // coordinate width
  localparam int DW    = CW + 1;        // coordinate difference width
  localparam int PW    = 2 * DW;        // product of two differences
  localparam int LW    = PW + 1;        // squared segment length
  localparam int SW    = PW + 2;        // dot product and squared distance, signed sum
  localparam int NW    = DW + LW;       // magnitude of d * dot
  localparam int QW    = DW;            // quotient width
  localparam int RW    = LW + 1;        // divider trial remainder width
  localparam int SPLIT = LW / 2 + 1;    // low slice of dot for the split multiply
  localparam int HW    = LW - SPLIT;    // high slice of dot
  localparam int RTW   = SW / 2;        // square root width
  localparam int SRW   = RTW + 4;       // square root remainder width
  localparam int DISTW = CW + 1;        // distance output width

  typedef enum logic [1:0] {
    SIDE_INT   = 2'd0,
    SIDE_START = 2'd1,
    SIDE_END   = 2'd2
  } side_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][CW-1:0] s;
    logic [2:0][CW-1:0] e;
    side_t              side;
  } geo_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    side_t              side;
  } pt_t;
endpackage
`default_nettype wire

@@ hdl/closest_point_on_segment_3d_unit.sv @@
// Channel   Signals                                         Direction
// request   in_valid, in_ready, point_*, start_*, end_*     into the block
// result    out_valid, out_ready, closest_*, distance,      out of the block
//           clamp_side
//
// One request enters per cycle while the output is not stalled on out_ready.
// The pipeline has 34 bit-serial stages for the projection divider and 35 for
// the distance square root, plus 6 front, 4 distance and 1 output stage.
// Reset clears only the valid bits; no request is in flight afterward.
// A full output register with out_ready low freezes every stage, so nothing is lost.
`default_nettype none
module closest_point_on_segment_3d_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [csg_pkg::CW-1:0]    point_x,
  input  wire logic [csg_pkg::CW-1:0]    point_y,
  input  wire logic [csg_pkg::CW-1:0]    point_z,
  input  wire logic [csg_pkg::CW-1:0]    start_x,
  input  wire logic [csg_pkg::CW-1:0]    start_y,
  input  wire logic [csg_pkg::CW-1:0]    start_z,
  input  wire logic [csg_pkg::CW-1:0]    end_x,
  input  wire logic [csg_pkg::CW-1:0]    end_y,
  input  wire logic [csg_pkg::CW-1:0]    end_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [csg_pkg::CW-1:0]         closest_x,
  output logic [csg_pkg::CW-1:0]         closest_y,
  output logic [csg_pkg::CW-1:0]         closest_z,
  output logic [csg_pkg::DISTW-1:0]      distance,
  output logic [1:0]                     clamp_side
);
  import csg_pkg::*;

  logic                  en;
  geo_t                  in_geo;
  logic                  pj_valid, dv_valid, ds_valid, sq_valid;
  geo_t                  pj_geo, dv_geo;
  logic [2:0][NW-1:0]    pj_num;
  logic [2:0]            pj_dneg;
  logic [LW-1:0]         pj_len;
  logic [2:0][DW-1:0]    dv_q;
  pt_t                   ds_pt, sq_pt, res_pt;
  logic [SW-1:0]         ds_d2;
  logic [DISTW-1:0]      sq_dist, res_dist;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    in_geo      = '0;
    in_geo.p[0] = point_x;
    in_geo.p[1] = point_y;
    in_geo.p[2] = point_z;
    in_geo.s[0] = start_x;
    in_geo.s[1] = start_y;
    in_geo.s[2] = start_z;
    in_geo.e[0] = end_x;
    in_geo.e[1] = end_y;
    in_geo.e[2] = end_z;
  end

  csg_proj u_proj (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .in_geo(in_geo),
    .out_valid(pj_valid), .out_geo(pj_geo), .out_num(pj_num),
    .out_dneg(pj_dneg), .out_len(pj_len)
  );

  csg_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(pj_valid), .in_geo(pj_geo),
    .in_num(pj_num), .in_dneg(pj_dneg), .in_len(pj_len),
    .out_valid(dv_valid), .out_geo(dv_geo), .out_q(dv_q)
  );

  csg_dist u_dist (
    .clk(clk), .rst(rst), .en(en), .in_valid(dv_valid), .in_geo(dv_geo),
    .in_q(dv_q), .out_valid(ds_valid), .out_pt(ds_pt), .out_d2(ds_d2)
  );

  csg_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(ds_valid), .in_pt(ds_pt),
    .in_n(ds_d2), .out_valid(sq_valid), .out_pt(sq_pt), .out_dist(sq_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_pt   <= sq_pt;
      res_dist <= sq_dist;
    end
  end

  assign closest_x  = res_pt.c[0];
  assign closest_y  = res_pt.c[1];
  assign closest_z  = res_pt.c[2];
  assign distance   = res_dist;
  assign clamp_side = res_pt.side;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sq_valid) && $stable(sq_dist) && $stable(ds_valid))
    else $error("pipeline moved during a stall");

  a_side_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (clamp_side == SIDE_INT || clamp_side == SIDE_START ||
                   clamp_side == SIDE_END))
    else $error("clamp side out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(closest_x) && $stable(closest_y)
      && $stable(closest_z) && $stable(distance) && $stable(clamp_side))
    else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire

@@ hdl/csg_proj.sv @@
`default_nettype none
module csg_proj (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire csg_pkg::geo_t                     in_geo,
  output logic                                   out_valid,
  output csg_pkg::geo_t                          out_geo,
  output logic [2:0][csg_pkg::NW-1:0]            out_num,
  output logic [2:0]                             out_dneg,
  output logic [csg_pkg::LW-1:0]                 out_len
);
  import csg_pkg::*;

  logic [5:0] vld;
  geo_t g1, g2, g3, g4, g5, g6;

  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] v1 [3];
  logic signed [PW-1:0] vd2 [3];
  logic signed [PW-1:0] dd2 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [SW-1:0] dot3;
  logic [LW-1:0]        len3;
  logic signed [DW-1:0] d3 [3];
  logic [DW-1:0]        dmag4 [3];
  logic [2:0]           dneg4, dneg5, dneg6;
  logic [LW-1:0]        dotm4, len4, len5, len6;
  logic [DW+SPLIT-1:0]  pl5 [3];
  logic [DW+HW-1:0]     ph5 [3];
  logic [NW-1:0]        num6 [3];
  side_t                side_next;

  // Projection test: at or below zero clamps to start, at or past len2 to end.
  always_comb begin
    if (dot3[SW-1] || dot3 == '0) begin
      side_next = SIDE_START;
    end else if (dot3[SW-2:0] >= len3) begin
      side_next = SIDE_END;
    end else begin
      side_next = SIDE_INT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= in_geo;
      for (int k = 0; k < 3; k++) begin
        d1[k] <= $signed({in_geo.e[k][CW-1], in_geo.e[k]})
               - $signed({in_geo.s[k][CW-1], in_geo.s[k]});
        v1[k] <= $signed({in_geo.p[k][CW-1], in_geo.p[k]})
               - $signed({in_geo.s[k][CW-1], in_geo.s[k]});
      end

      g2 <= g1;
      for (int k = 0; k < 3; k++) begin
        vd2[k] <= v1[k] * d1[k];
        dd2[k] <= d1[k] * d1[k];
        d2[k]  <= d1[k];
      end

      g3   <= g2;
      dot3 <= SW'(vd2[0]) + SW'(vd2[1]) + SW'(vd2[2]);
      len3 <= LW'($unsigned(dd2[0])) + LW'($unsigned(dd2[1])) + LW'($unsigned(dd2[2]));
      for (int k = 0; k < 3; k++) begin
        d3[k] <= d2[k];
      end

      g4    <= {g3.p, g3.s, g3.e, side_next};
      dotm4 <= dot3[LW-1:0];
      len4  <= len3;
      for (int k = 0; k < 3; k++) begin
        dmag4[k] <= d3[k][DW-1] ? DW'(-d3[k]) : DW'(d3[k]);
        dneg4[k] <= d3[k][DW-1];
      end

      // Wide product d * dot split into two partial products.
      g5    <= g4;
      len5  <= len4;
      dneg5 <= dneg4;
      for (int k = 0; k < 3; k++) begin
        pl5[k] <= dmag4[k] * dotm4[SPLIT-1:0];
        ph5[k] <= dmag4[k] * dotm4[LW-1:SPLIT];
      end

      g6    <= g5;
      len6  <= len5;
      dneg6 <= dneg5;
      for (int k = 0; k < 3; k++) begin
        num6[k] <= (NW'(ph5[k]) << SPLIT) + NW'(pl5[k]);
      end
    end
  end

  assign out_valid = vld[5];
  assign out_geo   = g6;
  assign out_dneg  = dneg6;
  assign out_len   = len6;
  assign out_num[0] = num6[0];
  assign out_num[1] = num6[1];
  assign out_num[2] = num6[2];
endmodule
`default_nettype wire

@@ hdl/csg_div.sv @@
`default_nettype none
module csg_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire csg_pkg::geo_t               in_geo,
  input  wire logic [2:0][csg_pkg::NW-1:0] in_num,
  input  wire logic [2:0]                  in_dneg,
  input  wire logic [csg_pkg::LW-1:0]      in_len,
  output logic                             out_valid,
  output csg_pkg::geo_t                    out_geo,
  output logic [2:0][csg_pkg::DW-1:0]      out_q
);
  import csg_pkg::*;

  logic [QW:0]   vld;
  geo_t          geo  [QW+1];
  logic [LW-1:0] len  [QW+1];
  logic [2:0]    dneg [QW+1];
  logic [LW-1:0] rem  [QW+1][3];
  logic [QW-1:0] lo   [QW+1][3];
  logic [QW-1:0] q    [QW+1][3];

  logic [RW-1:0] trial  [QW][3];
  logic          take   [QW][3];
  logic [LW-1:0] rem_nx [QW][3];

  // One quotient bit per stage, restoring. The quotient is below |d|, so the
  // upper numerator bits already start out below len2.
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      for (int k = 0; k < 3; k++) begin
        trial[j][k]  = {rem[j][k], lo[j][k][QW-1]};
        take[j][k]   = trial[j][k] >= {1'b0, len[j]};
        rem_nx[j][k] = take[j][k] ? LW'(trial[j][k] - {1'b0, len[j]}) : LW'(trial[j][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo[0]  <= in_geo;
      len[0]  <= in_len;
      dneg[0] <= in_dneg;
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= in_num[k][NW-1:QW];
        lo[0][k]  <= in_num[k][QW-1:0];
        q[0][k]   <= '0;
      end
      for (int j = 0; j < QW; j++) begin
        geo[j+1]  <= geo[j];
        len[j+1]  <= len[j];
        dneg[j+1] <= dneg[j];
        for (int k = 0; k < 3; k++) begin
          rem[j+1][k] <= rem_nx[j][k];
          lo[j+1][k]  <= {lo[j][k][QW-2:0], 1'b0};
          q[j+1][k]   <= {q[j][k][QW-2:0], take[j][k]};
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_geo   = geo[QW];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_q[k] = dneg[QW][k] ? DW'(-q[QW][k]) : DW'(q[QW][k]);
    end
  end
endmodule
`default_nettype wire

@@ hdl/csg_dist.sv @@
`default_nettype none
module csg_dist (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire csg_pkg::geo_t               in_geo,
  input  wire logic [2:0][csg_pkg::DW-1:0] in_q,
  output logic                             out_valid,
  output csg_pkg::pt_t                     out_pt,
  output logic [csg_pkg::SW-1:0]           out_d2
);
  import csg_pkg::*;

  logic [3:0]           vld;
  pt_t                  pt1, pt2, pt3, pt4;
  logic [CW-1:0]        p1 [3];
  logic signed [DW-1:0] dc2 [3];
  logic signed [PW-1:0] sq3 [3];
  logic [SW-1:0]        d2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1.side <= in_geo.side;
      for (int k = 0; k < 3; k++) begin
        p1[k] <= in_geo.p[k];
        case (in_geo.side)
          SIDE_INT:   pt1.c[k] <= in_geo.s[k] + in_q[k][CW-1:0];
          SIDE_START: pt1.c[k] <= in_geo.s[k];
          SIDE_END:   pt1.c[k] <= in_geo.e[k];
          default:    pt1.c[k] <= in_geo.s[k];
        endcase
      end

      pt2 <= pt1;
      for (int k = 0; k < 3; k++) begin
        dc2[k] <= $signed({pt1.c[k][CW-1], pt1.c[k]}) - $signed({p1[k][CW-1], p1[k]});
      end

      pt3 <= pt2;
      for (int k = 0; k < 3; k++) begin
        sq3[k] <= dc2[k] * dc2[k];
      end

      pt4  <= pt3;
      d2_4 <= SW'($unsigned(sq3[0])) + SW'($unsigned(sq3[1])) + SW'($unsigned(sq3[2]));
    end
  end

  assign out_valid = vld[3];
  assign out_pt    = pt4;
  assign out_d2    = d2_4;
endmodule
`default_nettype wire

@@ hdl/csg_sqrt.sv @@
`default_nettype none
module csg_sqrt (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire csg_pkg::pt_t           in_pt,
  input  wire logic [csg_pkg::SW-1:0] in_n,
  output logic                        out_valid,
  output csg_pkg::pt_t                out_pt,
  output logic [csg_pkg::DISTW-1:0]   out_dist
);
  import csg_pkg::*;

  logic [RTW:0]   vld;
  pt_t            pt   [RTW+1];
  logic [SW-1:0]  n    [RTW+1];
  logic [SRW-1:0] rem  [RTW+1];
  logic [RTW-1:0] root [RTW+1];

  logic [SRW-1:0] shifted [RTW];
  logic [SRW-1:0] trial   [RTW];
  logic           take    [RTW];

  // Digit by digit: two radicand bits in, one root bit out, per stage.
  always_comb begin
    for (int j = 0; j < RTW; j++) begin
      shifted[j] = {rem[j][SRW-3:0], n[j][SW-1:SW-2]};
      trial[j]   = {{(SRW-RTW-2){1'b0}}, root[j], 2'b01};
      take[j]    = shifted[j] >= trial[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RTW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt[0]   <= in_pt;
      n[0]    <= in_n;
      rem[0]  <= '0;
      root[0] <= '0;
      for (int j = 0; j < RTW; j++) begin
        pt[j+1]   <= pt[j];
        n[j+1]    <= {n[j][SW-3:0], 2'b00};
        rem[j+1]  <= take[j] ? shifted[j] - trial[j] : shifted[j];
        root[j+1] <= {root[j][RTW-2:0], take[j]};
      end
    end
  end

  assign out_valid = vld[RTW];
  assign out_pt    = pt[RTW];
  assign out_dist  = (|root[RTW][RTW-1:DISTW]) ? {DISTW{1'b1}} : root[RTW][DISTW-1:0];
endmodule
`default_nettype wire
